// ===== src/cruise_control_mode_fsm_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cruise control mode unit
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CRUISE_CONTROL_MODE_FSM_UNIT_ASSERT_SVH
`define CRUISE_CONTROL_MODE_FSM_UNIT_ASSERT_SVH

// same-cycle implication
`define CCMF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ccmf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccmf_pkg
// Shared types and constants for the cruise control mode unit.
// ----------------------------------------------------------------------------
package ccmf_pkg;

	localparam int DEFAULT_SPEED_BITS = 8;
	localparam int OP_W               = 4;
	localparam int SPD_IN_W           = 8;
	localparam int CMD_W              = 2;

	typedef enum logic [OP_W-1:0] {
		OP_SPEED    = 4'd0,
		OP_TURN_ON  = 4'd1,
		OP_TURN_OFF = 4'd2,
		OP_SET      = 4'd3,
		OP_INC      = 4'd4,
		OP_DEC      = 4'd5,
		OP_RESUME   = 4'd6,
		OP_BRAKE    = 4'd7,
		OP_GAS      = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		MODE_INACTIVE = 3'd0,
		MODE_IDLE     = 3'd1,
		MODE_ACTIVE   = 3'd2,
		MODE_HOLD     = 3'd3,
		MODE_STANDBY  = 3'd4
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCEL = 2'd0,
		CMD_DECEL = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	// registered event word handed to the core
	typedef struct packed {
		logic                valid;
		logic [OP_W-1:0]     op;
		logic [SPD_IN_W-1:0] spd;
	} evt_t;

	// result of one event, before the output register
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} res_t;

endpackage

// ===== src/ccmf_in_reg.sv =====
// ----------------------------------------------------------------------------
// ccmf_in_reg
// Input register for event words; holds while the core cannot advance.
// ----------------------------------------------------------------------------
module ccmf_in_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          event_valid,
	output logic                          event_stall,
	input  logic [ccmf_pkg::OP_W-1:0]     operation,
	input  logic [ccmf_pkg::SPD_IN_W-1:0] speed_value,
	input  logic                          adv,
	output ccmf_pkg::evt_t                evt
);

	logic                          valid_s1;
	logic [ccmf_pkg::OP_W-1:0]     op_s1;
	logic [ccmf_pkg::SPD_IN_W-1:0] spd_s1;

	assign event_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!event_stall) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && !event_stall) begin
			op_s1  <= operation;
			spd_s1 <= speed_value;
		end
	end

	assign evt.valid = valid_s1;
	assign evt.op    = op_s1;
	assign evt.spd   = spd_s1;

endmodule

// ===== src/ccmf_core.sv =====
// ----------------------------------------------------------------------------
// ccmf_core
// Mode state machine, set/measured speed registers and command decision.
// ----------------------------------------------------------------------------
module ccmf_core #(
	parameter int SPEED_BITS = ccmf_pkg::DEFAULT_SPEED_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ccmf_pkg::evt_t evt,
	input  logic           adv,
	output ccmf_pkg::res_t res
);

	ccmf_pkg::mode_t       mode_q, mode_d;
	logic [SPEED_BITS-1:0] target_q, target_d;
	logic [SPEED_BITS-1:0] meas_q, meas_d;
	logic                  engaged_q, engaged_d;
	logic [SPEED_BITS-1:0] spd_w;
	logic                  take;

	// sample taken modulo 2^SPEED_BITS (zero-extended when wider)
	assign spd_w = SPEED_BITS'(evt.spd);
	assign take  = evt.valid && adv;

	// next state
	always_comb begin
		mode_d   = mode_q;
		target_d = target_q;
		meas_d   = meas_q;
		case (ccmf_pkg::op_t'(evt.op))
			ccmf_pkg::OP_SPEED: begin
				meas_d = spd_w;
				if (mode_q == ccmf_pkg::MODE_STANDBY && spd_w <= target_q) begin
					mode_d = ccmf_pkg::MODE_ACTIVE;
				end
			end
			ccmf_pkg::OP_TURN_ON: begin
				if (mode_q == ccmf_pkg::MODE_INACTIVE) begin
					mode_d = ccmf_pkg::MODE_IDLE;
				end
			end
			ccmf_pkg::OP_TURN_OFF: begin
				mode_d = ccmf_pkg::MODE_INACTIVE;
			end
			ccmf_pkg::OP_SET: begin
				if (mode_q == ccmf_pkg::MODE_IDLE || mode_q == ccmf_pkg::MODE_HOLD ||
				    mode_q == ccmf_pkg::MODE_STANDBY) begin
					mode_d   = ccmf_pkg::MODE_ACTIVE;
					target_d = meas_q;
				end
			end
			ccmf_pkg::OP_INC: begin
				if (mode_q == ccmf_pkg::MODE_ACTIVE && target_q != '1) begin
					target_d = target_q + 1'b1;
				end
			end
			ccmf_pkg::OP_DEC: begin
				if (mode_q == ccmf_pkg::MODE_ACTIVE && target_q != '0) begin
					target_d = target_q - 1'b1;
				end
			end
			ccmf_pkg::OP_RESUME: begin
				if (mode_q == ccmf_pkg::MODE_HOLD) begin
					mode_d = ccmf_pkg::MODE_ACTIVE;
				end
			end
			ccmf_pkg::OP_BRAKE: begin
				if (mode_q == ccmf_pkg::MODE_ACTIVE || mode_q == ccmf_pkg::MODE_STANDBY) begin
					mode_d = ccmf_pkg::MODE_HOLD;
				end
			end
			ccmf_pkg::OP_GAS: begin
				if (mode_q == ccmf_pkg::MODE_ACTIVE) begin
					mode_d = ccmf_pkg::MODE_STANDBY;
				end
			end
			default: begin
			end
		endcase
	end

	// outputs: regulate while active, one stop on leaving
	always_comb begin
		engaged_d = engaged_q;
		res.valid = 1'b0;
		res.cmd   = ccmf_pkg::CMD_ACCEL;
		if (mode_d == ccmf_pkg::MODE_ACTIVE) begin
			engaged_d = 1'b1;
			if (meas_d < target_d) begin
				res.valid = evt.valid;
				res.cmd   = ccmf_pkg::CMD_ACCEL;
			end else if (meas_d > target_d) begin
				res.valid = evt.valid;
				res.cmd   = ccmf_pkg::CMD_DECEL;
			end
		end else if (engaged_q) begin
			engaged_d = 1'b0;
			res.valid = evt.valid;
			res.cmd   = ccmf_pkg::CMD_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ccmf_pkg::MODE_INACTIVE;
			target_q  <= '0;
			meas_q    <= '0;
			engaged_q <= 1'b0;
		end else if (take) begin
			mode_q    <= mode_d;
			target_q  <= target_d;
			meas_q    <= meas_d;
			engaged_q <= engaged_d;
		end
	end

endmodule

// ===== src/ccmf_out_reg.sv =====
// ----------------------------------------------------------------------------
// ccmf_out_reg
// Result register for command words; holds the core while a stalled word waits.
// ----------------------------------------------------------------------------
module ccmf_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ccmf_pkg::res_t             res,
	output logic                       adv,
	output logic                       cmd_valid,
	input  logic                       cmd_stall,
	output logic [ccmf_pkg::CMD_W-1:0] command
);

	logic           cmd_valid_s2;
	ccmf_pkg::cmd_t cmd_s2;

	// register is free when empty or being taken this cycle
	assign adv = !cmd_valid_s2 || !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s2 <= 1'b0;
		end else if (adv) begin
			cmd_valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			cmd_s2 <= res.cmd;
		end
	end

	assign cmd_valid = cmd_valid_s2;
	assign command   = cmd_s2;

endmodule

// ===== src/cruise_control_mode_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// cruise_control_mode_fsm_unit
// Cruise control mode controller: event words in, regulation commands out.
// ----------------------------------------------------------------------------
// Takes one event word per cycle (speed sample, turn on/off, set, increase,
// decrease, resume, brake, gas) and returns zero or one command word for it,
// in order. While active it asks to accelerate or decelerate toward the set
// speed (nothing when equal); the first event that finds it no longer active
// after regulating yields one stop word. Set-speed steps saturate at the
// ends of the SPEED_BITS range; speed samples are taken modulo 2^SPEED_BITS.
// Throughput is one event per cycle while the command side keeps up; each
// event word passes the input register, then the mode logic, and its
// command word is registered in the result register before the output.
// A command word held in the result register by a stall freezes the
// core: the input register keeps its event word and the event side
// stalls until the command word is taken.
// ----------------------------------------------------------------------------
`include "cruise_control_mode_fsm_unit_assert.svh"

module cruise_control_mode_fsm_unit #(
	parameter int SPEED_BITS = ccmf_pkg::DEFAULT_SPEED_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// event channel
	input  logic                          event_valid,
	output logic                          event_stall,
	input  logic [ccmf_pkg::OP_W-1:0]     operation,
	input  logic [ccmf_pkg::SPD_IN_W-1:0] speed_value,
	// command channel
	output logic                          cmd_valid,
	input  logic                          cmd_stall,
	output logic [ccmf_pkg::CMD_W-1:0]    command
);

	ccmf_pkg::evt_t evt;   // registered event word
	ccmf_pkg::res_t res;   // decision for that word
	logic           adv;   // result register can take a word

	ccmf_in_reg u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.operation   (operation),
		.speed_value (speed_value),
		.adv         (adv),
		.evt         (evt)
	);

	ccmf_core #(
		.SPEED_BITS (SPEED_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt),
		.adv    (adv),
		.res    (res)
	);

	ccmf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.adv       (adv),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.command   (command)
	);

	// checks
	`CCMF_ASSERT_SAME(a_stall_only_when_full, event_stall, evt.valid, "stall with empty input stage")
	`CCMF_ASSERT_SAME(a_result_needs_event, res.valid, evt.valid, "result without an event")
	`CCMF_ASSERT_NEXT(a_result_lands, res.valid && adv, cmd_valid, "result word dropped")
	`CCMF_ASSERT_NEXT(a_held_event_stable, evt.valid && !adv, $stable(evt.op), "held event changed")

endmodule
